[src/stap_pkg.sv]
package stap_pkg;

	localparam int TRACE_POINTS = 512;
	localparam int ADDR_W = $clog2(TRACE_POINTS);
	localparam int LEVEL_W = 16;
	localparam int INDEX_W = 9;
	localparam int FREQ_W = 32;
	localparam int MODE_W = 3;
	localparam int CFG_DATA_W = 3;

	localparam logic signed [LEVEL_W-1:0] PEAK_FLOOR = -16'sd4800;
	localparam logic [FREQ_W-1:0] MIN_PEAK_FREQ = 32'd1000000;

	typedef enum logic [1:0] {
		REQ_MEASURE = 2'd0,
		REQ_COPY    = 2'd1,
		REQ_FRESH   = 2'd2,
		REQ_NONE    = 2'd3
	} req_code_t;

	typedef enum logic [MODE_W-1:0] {
		AVG_OFF  = 3'd0,
		AVG_MIN  = 3'd1,
		AVG_MAX  = 3'd2,
		AVG_BY2  = 3'd3,
		AVG_BY4  = 3'd4,
		AVG_BY8  = 3'd5
	} avg_mode_t;

	typedef enum logic {
		CFG_AVERAGE_MODE = 1'b0,
		CFG_SUBTRACT     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]                req_type;
		logic [INDEX_W-1:0]        point_index;
		logic [FREQ_W-1:0]         frequency_hz;
		logic signed [LEVEL_W-1:0] measured_level;
		logic                      last_point;
	} stap_in_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] trace_level;
		logic                      sweep_done;
		logic                      peak_found;
		logic [INDEX_W-1:0]        peak_point;
		logic [FREQ_W-1:0]         peak_frequency;
		logic signed [LEVEL_W-1:0] peak_value;
	} stap_out_t;

	// One finished measured point as seen by the peak tracker.
	typedef struct packed {
		logic                      update;
		logic                      last;
		logic [INDEX_W-1:0]        point;
		logic [FREQ_W-1:0]         freq;
		logic signed [LEVEL_W-1:0] level;
	} stap_peak_cmd_t;

	typedef struct packed {
		logic                      found;
		logic [INDEX_W-1:0]        point;
		logic [FREQ_W-1:0]         freq;
		logic signed [LEVEL_W-1:0] value;
	} stap_peak_rpt_t;

endpackage

[src/stap_ram.sv]
module stap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/stap_level.sv]
module stap_level (
	input  stap_pkg::stap_in_t                  item,
	input  logic signed [stap_pkg::LEVEL_W-1:0] trace_old,
	input  logic signed [stap_pkg::LEVEL_W-1:0] ref_old,
	input  logic [stap_pkg::MODE_W-1:0]         mode,
	input  logic                                subtract,
	input  logic                                fresh,
	output logic signed [stap_pkg::LEVEL_W-1:0] level
);

	logic signed [stap_pkg::LEVEL_W:0]   diff_ref;
	logic signed [stap_pkg::LEVEL_W-1:0] meas;
	logic signed [stap_pkg::LEVEL_W:0]   delta;
	logic signed [stap_pkg::LEVEL_W:0]   step;
	logic signed [stap_pkg::LEVEL_W:0]   avg_sum;

	always_comb begin
		diff_ref = {item.measured_level[stap_pkg::LEVEL_W-1], item.measured_level}
			- {ref_old[stap_pkg::LEVEL_W-1], ref_old};
		if (!subtract) begin
			meas = item.measured_level;
		end else if (diff_ref[stap_pkg::LEVEL_W] != diff_ref[stap_pkg::LEVEL_W-1]) begin
			// Overflow: the sign bit tells which rail to clip to.
			meas = diff_ref[stap_pkg::LEVEL_W] ? {1'b1, {(stap_pkg::LEVEL_W-1){1'b0}}}
				: {1'b0, {(stap_pkg::LEVEL_W-1){1'b1}}};
		end else begin
			meas = diff_ref[stap_pkg::LEVEL_W-1:0];
		end

		// (old*(n-1) + new) / n equals old + (new - old) / n, floored the same way.
		delta = {meas[stap_pkg::LEVEL_W-1], meas}
			- {trace_old[stap_pkg::LEVEL_W-1], trace_old};
		case (mode)
			stap_pkg::AVG_BY2: step = delta >>> 1;
			stap_pkg::AVG_BY4: step = delta >>> 2;
			stap_pkg::AVG_BY8: step = delta >>> 3;
			default:           step = '0;
		endcase
		avg_sum = {trace_old[stap_pkg::LEVEL_W-1], trace_old} + step;

		if (fresh || mode == stap_pkg::AVG_OFF) begin
			level = meas;
		end else begin
			case (mode)
				stap_pkg::AVG_MIN: level = (trace_old > meas) ? meas : trace_old;
				stap_pkg::AVG_MAX: level = (trace_old < meas) ? meas : trace_old;
				stap_pkg::AVG_BY2,
				stap_pkg::AVG_BY4,
				stap_pkg::AVG_BY8: level = avg_sum[stap_pkg::LEVEL_W-1:0];
				default:           level = trace_old;
			endcase
		end
	end

endmodule

[src/stap_peak.sv]
module stap_peak (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stap_pkg::stap_peak_cmd_t cmd,
	output stap_pkg::stap_peak_rpt_t rpt
);

	stap_pkg::stap_peak_rpt_t peak_q;
	logic                     take;

	always_comb begin
		take = cmd.update && (cmd.freq > stap_pkg::MIN_PEAK_FREQ)
			&& (cmd.level > peak_q.value);
		if (take) begin
			rpt.found = 1'b1;
			rpt.point = cmd.point;
			rpt.freq  = cmd.freq;
			rpt.value = cmd.level;
		end else begin
			rpt = peak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q.found <= 1'b0;
			peak_q.point <= '0;
			peak_q.freq  <= '0;
			peak_q.value <= stap_pkg::PEAK_FLOOR;
		end else if (cmd.update && cmd.last) begin
			// The sweep is reported this cycle; start the next one from the floor.
			peak_q.found <= 1'b0;
			peak_q.point <= '0;
			peak_q.freq  <= '0;
			peak_q.value <= stap_pkg::PEAK_FLOOR;
		end else if (take) begin
			peak_q <= rpt;
		end
	end

endmodule

[src/spectrum_trace_average_peak.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data (stap_in_t)
// out       output     out_valid/out_stall  out_data (stap_out_t)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// One item per cycle unless the output stalls; items go through stage 1 and out_data_q.
// The trace and reference RAMs are read at the input transfer and written from
// stage 1, so back-to-back items to one point are served by a one-entry bypass.
// Reset marks the next sweep fresh and clears the running peak, the configuration
// and the valid flags; the RAMs and the data registers are not cleared.
// A stall on the output holds stage 1, which then stalls the input.
module spectrum_trace_average_peak (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  stap_pkg::stap_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output stap_pkg::stap_out_t               out_data,
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [stap_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [stap_pkg::MODE_W-1:0] avg_mode_q;
	logic                        subtract_q;
	logic                        fresh_q;

	logic                        accept;
	logic                        s1_fire;
	logic                        s1_valid_s1;
	stap_pkg::stap_in_t          item_s1;
	logic [stap_pkg::ADDR_W-1:0] in_addr;
	logic [stap_pkg::ADDR_W-1:0] addr_s1;

	logic                              trace_we;
	logic signed [stap_pkg::LEVEL_W-1:0] trace_wdata;
	logic [stap_pkg::LEVEL_W-1:0]      trace_rdata;
	logic                              ref_we;
	logic [stap_pkg::LEVEL_W-1:0]      ref_rdata;

	logic                              trace_hit_s1;
	logic                              ref_hit_s1;
	logic [stap_pkg::LEVEL_W-1:0]      trace_fwd_s1;
	logic [stap_pkg::LEVEL_W-1:0]      ref_fwd_s1;
	logic signed [stap_pkg::LEVEL_W-1:0] trace_old;
	logic signed [stap_pkg::LEVEL_W-1:0] ref_old;
	logic signed [stap_pkg::LEVEL_W-1:0] new_level;

	logic                        is_measure;
	logic                        is_copy;
	stap_pkg::stap_peak_cmd_t    peak_cmd;
	stap_pkg::stap_peak_rpt_t    peak_rpt;
	stap_pkg::stap_out_t         result;
	logic                        out_valid_q;
	stap_pkg::stap_out_t         out_data_q;

	assign in_addr  = in_data.point_index[stap_pkg::ADDR_W-1:0];
	assign addr_s1  = item_s1.point_index[stap_pkg::ADDR_W-1:0];
	assign s1_fire  = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_s1 && !s1_fire;
	assign accept   = in_valid && !in_stall;

	assign is_measure = item_s1.req_type == stap_pkg::REQ_MEASURE;
	assign is_copy    = item_s1.req_type == stap_pkg::REQ_COPY;
	assign trace_we   = s1_fire && is_measure;
	assign ref_we     = s1_fire && is_copy;
	assign trace_wdata = new_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_mode_q <= '0;
			subtract_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				stap_pkg::CFG_AVERAGE_MODE: avg_mode_q <= cfg_data;
				stap_pkg::CFG_SUBTRACT:     subtract_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// The RAM read issued at this transfer misses a write landing on the same edge,
	// so the written value is kept alongside the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1      <= in_data;
			trace_hit_s1 <= trace_we && (addr_s1 == in_addr);
			trace_fwd_s1 <= trace_wdata;
			ref_hit_s1   <= ref_we && (addr_s1 == in_addr);
			ref_fwd_s1   <= trace_old;
		end
	end

	stap_ram #(
		.WIDTH(stap_pkg::LEVEL_W),
		.DEPTH(stap_pkg::TRACE_POINTS)
	) u_trace_ram (
		.clk     (clk),
		.wr_en   (trace_we),
		.wr_addr (addr_s1),
		.wr_data (trace_wdata),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (trace_rdata)
	);

	stap_ram #(
		.WIDTH(stap_pkg::LEVEL_W),
		.DEPTH(stap_pkg::TRACE_POINTS)
	) u_ref_ram (
		.clk     (clk),
		.wr_en   (ref_we),
		.wr_addr (addr_s1),
		.wr_data (trace_old),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (ref_rdata)
	);

	assign trace_old = trace_hit_s1 ? trace_fwd_s1 : trace_rdata;
	assign ref_old   = ref_hit_s1 ? ref_fwd_s1 : ref_rdata;

	stap_level u_level (
		.item      (item_s1),
		.trace_old (trace_old),
		.ref_old   (ref_old),
		.mode      (avg_mode_q),
		.subtract  (subtract_q),
		.fresh     (fresh_q),
		.level     (new_level)
	);

	always_comb begin
		peak_cmd.update = trace_we;
		peak_cmd.last   = item_s1.last_point;
		peak_cmd.point  = item_s1.point_index;
		peak_cmd.freq   = item_s1.frequency_hz;
		peak_cmd.level  = new_level;
	end

	stap_peak u_peak (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (peak_cmd),
		.rpt    (peak_rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
		end else if (s1_fire) begin
			if (item_s1.req_type == stap_pkg::REQ_FRESH) begin
				fresh_q <= 1'b1;
			end else if (is_measure && item_s1.last_point) begin
				fresh_q <= 1'b0;
			end
		end
	end

	always_comb begin
		result = '0;
		case (item_s1.req_type)
			stap_pkg::REQ_MEASURE: begin
				result.trace_level = new_level;
				if (item_s1.last_point) begin
					result.sweep_done     = 1'b1;
					result.peak_found     = peak_rpt.found;
					result.peak_point     = peak_rpt.point;
					result.peak_frequency = peak_rpt.freq;
					result.peak_value     = peak_rpt.value;
				end
			end
			stap_pkg::REQ_COPY: result.trace_level = trace_old;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
